FILE: rtl/tcdr_pkg.sv
// tcdr_pkg: shared types and constants for the text console dirty rectangle engine
// field widths, request codes, fixed cell values and the sequencer state type
// no dependencies
`default_nettype none

package tcdr_pkg;

  localparam int REQ_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int RADDR_W = 11;
  localparam int WORD_W  = 16;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int THR_W   = 8;

  localparam logic [WORD_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE    = 8'd10;
  localparam logic [THR_W-1:0]  THR_RESET  = 8'd10;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_FLUSH = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FSETUP,
    ST_FADDR,
    ST_FWALK,
    ST_FDRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/tcdr_if.sv
// tcdr_req_if / tcdr_rsp_if: valid/ready channels of the console engine
// request item and result item payloads; depends on tcdr_pkg
`default_nettype none

interface tcdr_req_if import tcdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [CHAR_W-1:0]  char_code;
  logic [ATTR_W-1:0]  attr_byte;
  logic [RADDR_W-1:0] read_address;

  modport source (output valid, req_type, char_code, attr_byte, read_address,
                  input ready);
  modport sink   (input valid, req_type, char_code, attr_byte, read_address,
                  output ready);
endinterface

interface tcdr_rsp_if import tcdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_data;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic              region_dirty;
  logic              flushed;

  modport source (output valid, read_data, cursor_col, cursor_row, region_dirty, flushed,
                  input ready);
  modport sink   (input valid, read_data, cursor_col, cursor_row, region_dirty, flushed,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/text_console_dirty_rect_engine.sv
// text_console_dirty_rect_engine: text console with dirty rectangle and display flush
// depends on tcdr_pkg and the channel interfaces in tcdr_if.sv
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        req_type, char_code, attr_byte, read_address
//   rsp      out  valid/ready        read_data, cursor_col, cursor_row, region_dirty, flushed
//   cfg      in   cfg_wen (no wait)  cfg_wdata = auto-flush put limit
//
// put, read and clear pass through the exec and done states; the next item is taken on the
// cycle the result is loaded into the output register
// a flush adds the setup, address, walk and drain states: one text store read and one
// display write per dirty cell, through the single walk counter pair
// after reset the display memory is zeroed, one word a cycle, before the first item
// is taken; cfg writes always land
// a stalled result holds the block in its done state until rsp.ready
`default_nettype none

module text_console_dirty_rect_engine import tcdr_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic             clk,
  input  wire logic             rst,
  tcdr_req_if.sink              req,
  tcdr_rsp_if.source            rsp,
  input  wire logic             cfg_wen,
  input  wire logic [THR_W-1:0] cfg_wdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);   // cell address
  localparam int RW    = $clog2(ROWS);    // physical row index
  localparam int FW    = $clog2(COLUMNS + 1);  // per-row fill count
  localparam logic [31:0] CELLS_32 = 32'(CELLS);

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic [AW-1:0]      clr_addr;     // display zeroing sweep after reset

  // accepted item
  req_type_t          req_r;
  logic [CHAR_W-1:0]  ch_r;
  logic [ATTR_W-1:0]  attr_r;
  logic [RADDR_W-1:0] addr_r;

  logic [THR_W-1:0]   thr;

  // cursor; rows live in a ring, logical row r sits at physical (r + base) mod ROWS
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [RW-1:0]      cur_phys;
  logic [AW-1:0]      cur_row_addr;  // cur_phys * COLUMNS
  logic [RW-1:0]      base;

  logic               dirty_flag;
  logic [COL_W-1:0]   dirty_left, dirty_right;
  logic [ROW_W-1:0]   dirty_top, dirty_bottom;
  logic [THR_W-1:0]   pc;            // print count
  logic               did;
  logic               rd_hit;

  // cells at or beyond the fill count of their physical row read as blank
  logic [FW-1:0]      fc [ROWS];

  // flush walk
  logic [COL_W-1:0]   walk_x;
  logic [ROW_W-1:0]   walk_y;
  logic [RW-1:0]      walk_phys;
  logic [AW-1:0]      text_row_addr;
  logic [AW-1:0]      disp_row_addr;
  logic               pend_valid;
  logic               pend_blank;
  logic [AW-1:0]      pend_addr;

  // memories
  logic [WORD_W-1:0]  text_mem [CELLS];
  logic [WORD_W-1:0]  disp_mem [CELLS];
  logic [WORD_W-1:0]  text_rdata, disp_rdata;

  // ---------------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------------
  logic               is_nl, col_wrap, at_bottom, row_adv, scroll_c;
  logic [THR_W-1:0]   pc_inc;
  logic               put_flush, dirty_after, rd_hit_c;
  logic [RW-1:0]      cur_phys_adv, base_adv, walk_phys_adv, top_phys;
  logic [AW:0]        cur_addr_sum, text_row_sum;
  logic [AW-1:0]      cur_addr_adv, text_row_adv;
  logic [ROW_W:0]     top_sum;
  logic [ROW_W-1:0]   mul_in;
  logic [AW-1:0]      mul_prod;
  logic               walk_row_end, walk_last;

  logic               out_free, out_load, in_acc;
  logic               text_we, text_re, disp_we, disp_re;
  logic [AW-1:0]      text_waddr, text_raddr, disp_waddr, disp_raddr;
  logic [WORD_W-1:0]  text_wdata, disp_wdata;

  always_comb begin
    is_nl     = (ch_r == NEWLINE);
    col_wrap  = (cur_col == COL_W'(COLUMNS - 1));
    at_bottom = (cur_row == ROW_W'(ROWS - 1));
    row_adv   = is_nl || col_wrap;
    scroll_c  = row_adv && at_bottom;
    pc_inc    = pc + THR_W'(1);
    put_flush = (pc_inc >= thr) || is_nl;
    // a printable put always leaves the region dirty, a scroll marks it all
    dirty_after = !is_nl || scroll_c || dirty_flag;
    rd_hit_c  = ({21'd0, addr_r} < CELLS_32);

    cur_phys_adv  = (cur_phys == RW'(ROWS - 1)) ? '0 : cur_phys + RW'(1);
    base_adv      = (base == RW'(ROWS - 1)) ? '0 : base + RW'(1);
    walk_phys_adv = (walk_phys == RW'(ROWS - 1)) ? '0 : walk_phys + RW'(1);

    cur_addr_sum = {1'b0, cur_row_addr} + (AW+1)'(COLUMNS);
    cur_addr_adv = (cur_addr_sum >= (AW+1)'(CELLS)) ? AW'(cur_addr_sum - (AW+1)'(CELLS))
                                                    : AW'(cur_addr_sum);
    text_row_sum = {1'b0, text_row_addr} + (AW+1)'(COLUMNS);
    text_row_adv = (text_row_sum >= (AW+1)'(CELLS)) ? AW'(text_row_sum - (AW+1)'(CELLS))
                                                    : AW'(text_row_sum);

    top_sum  = {1'b0, dirty_top} + (ROW_W+1)'(base);
    top_phys = (top_sum >= (ROW_W+1)'(ROWS)) ? RW'(top_sum - (ROW_W+1)'(ROWS))
                                             : RW'(top_sum);

    // one row-to-address multiplier, shared by the two flush setup steps
    mul_in   = (state == ST_FSETUP) ? dirty_top : ROW_W'(walk_phys);
    mul_prod = AW'(32'(mul_in) * COLUMNS);

    walk_row_end = (walk_x == dirty_right);
    walk_last    = walk_row_end && (walk_y == dirty_bottom);
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state, handshakes and memory strobes
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    out_free   = !rsp.valid || rsp.ready;
    out_load   = (state == ST_DONE) && out_free;
    req.ready  = (state == ST_IDLE) || out_load;
    in_acc     = req.valid && req.ready;

    text_we    = (state == ST_EXEC) && (req_r == REQ_PUT) && !is_nl;
    text_waddr = cur_row_addr + AW'(cur_col);
    text_wdata = {attr_r, ch_r};
    text_re    = (state == ST_FWALK);
    text_raddr = text_row_addr + AW'(walk_x);

    disp_we    = (state == ST_INIT) || pend_valid;
    disp_waddr = (state == ST_INIT) ? clr_addr : pend_addr;
    disp_wdata = (state == ST_INIT) ? '0 : (pend_blank ? BLANK_CELL : text_rdata);
    disp_re    = (state == ST_EXEC) && (req_r == REQ_READ) && rd_hit_c;
    disp_raddr = AW'(addr_r);

    case (state)
      ST_INIT: begin
        if (clr_addr == AW'(CELLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (req_r)
          REQ_PUT:   state_next = (put_flush && dirty_after) ? ST_FSETUP : ST_DONE;
          REQ_FLUSH: state_next = dirty_flag ? ST_FSETUP : ST_DONE;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_FSETUP: state_next = ST_FADDR;
      ST_FADDR:  state_next = ST_FWALK;
      ST_FWALK: begin
        if (walk_last) state_next = ST_FDRAIN;
      end
      ST_FDRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) state_next = in_acc ? ST_EXEC : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else     state <= state_next;
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      thr          <= THR_RESET;
      cur_col      <= '0;
      cur_row      <= '0;
      cur_phys     <= '0;
      cur_row_addr <= '0;
      base         <= '0;
      dirty_flag   <= 1'b1;
      dirty_left   <= '0;
      dirty_right  <= COL_W'(COLUMNS - 1);
      dirty_top    <= '0;
      dirty_bottom <= ROW_W'(ROWS - 1);
      pc           <= '0;
      did          <= 1'b0;
      rd_hit       <= 1'b0;
      pend_valid   <= 1'b0;
      for (int r = 0; r < ROWS; r++) fc[r] <= '0;
    end else begin
      if (cfg_wen) thr <= cfg_wdata;
      pend_valid <= 1'b0;

      if (in_acc) begin
        req_r  <= req_type_t'(req.req_type);
        ch_r   <= req.char_code;
        attr_r <= req.attr_byte;
        addr_r <= req.read_address;
      end

      case (state)
        ST_INIT: clr_addr <= clr_addr + AW'(1);

        ST_EXEC: begin
          did    <= 1'b0;
          rd_hit <= (req_r == REQ_READ) && rd_hit_c;
          case (req_r)
            REQ_PUT: begin
              pc <= put_flush ? '0 : pc_inc;
              if (!is_nl) begin
                fc[cur_phys] <= FW'(cur_col + COL_W'(1));
                if (!dirty_flag) begin
                  dirty_left   <= cur_col;
                  dirty_right  <= cur_col;
                  dirty_top    <= cur_row;
                  dirty_bottom <= cur_row;
                end else begin
                  if (cur_col < dirty_left)   dirty_left   <= cur_col;
                  if (cur_col > dirty_right)  dirty_right  <= cur_col;
                  if (cur_row < dirty_top)    dirty_top    <= cur_row;
                  if (cur_row > dirty_bottom) dirty_bottom <= cur_row;
                end
                dirty_flag <= 1'b1;
              end
              cur_col <= row_adv ? '0 : cur_col + COL_W'(1);
              if (row_adv) begin
                // physical row always steps; a scroll rotates the ring instead
                cur_phys     <= cur_phys_adv;
                cur_row_addr <= cur_addr_adv;
                if (at_bottom) begin
                  base         <= base_adv;
                  fc[base]     <= '0;
                  dirty_flag   <= 1'b1;
                  dirty_left   <= '0;
                  dirty_right  <= COL_W'(COLUMNS - 1);
                  dirty_top    <= '0;
                  dirty_bottom <= ROW_W'(ROWS - 1);
                end else begin
                  cur_row <= cur_row + ROW_W'(1);
                end
              end
            end
            REQ_CLEAR: begin
              for (int r = 0; r < ROWS; r++) fc[r] <= '0;
              base         <= '0;
              cur_phys     <= '0;
              cur_row_addr <= '0;
              cur_col      <= '0;
              cur_row      <= '0;
              dirty_flag   <= 1'b1;
              dirty_left   <= '0;
              dirty_right  <= COL_W'(COLUMNS - 1);
              dirty_top    <= '0;
              dirty_bottom <= ROW_W'(ROWS - 1);
            end
            default: ;
          endcase
        end

        ST_FSETUP: begin
          walk_x        <= dirty_left;
          walk_y        <= dirty_top;
          walk_phys     <= top_phys;
          disp_row_addr <= mul_prod;
        end

        ST_FADDR: text_row_addr <= mul_prod;

        ST_FWALK: begin
          pend_valid <= 1'b1;
          pend_addr  <= disp_row_addr + AW'(walk_x);
          pend_blank <= (walk_x >= COL_W'(fc[walk_phys]));
          if (walk_row_end) begin
            walk_x        <= dirty_left;
            walk_y        <= walk_y + ROW_W'(1);
            walk_phys     <= walk_phys_adv;
            text_row_addr <= text_row_adv;
            disp_row_addr <= disp_row_addr + AW'(COLUMNS);
          end else begin
            walk_x <= walk_x + COL_W'(1);
          end
        end

        ST_FDRAIN: begin
          dirty_flag <= 1'b0;
          did        <= 1'b1;
        end

        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (text_we) text_mem[text_waddr] <= text_wdata;
    if (text_re) text_rdata <= text_mem[text_raddr];
  end

  always_ff @(posedge clk) begin
    if (disp_we) disp_mem[disp_waddr] <= disp_wdata;
    if (disp_re) disp_rdata <= disp_mem[disp_raddr];
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.read_data    <= rd_hit ? disp_rdata : '0;
      rsp.cursor_col   <= cur_col;
      rsp.cursor_row   <= cur_row;
      rsp.region_dirty <= dirty_flag;
      rsp.flushed      <= did;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_init_once: assert property (@(posedge clk) disable iff (rst)
    state != ST_INIT |=> state != ST_INIT)
    else $error("display zeroing sweep reentered");

  a_row_addr: assert property (@(posedge clk) disable iff (rst)
    cur_row_addr == AW'(32'(cur_phys) * COLUMNS))
    else $error("cursor row address out of step with physical row");

  a_pend_walk: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == ST_FWALK || state == ST_FDRAIN))
    else $error("display write outside a flush walk");

  a_flush_clean: assert property (@(posedge clk) disable iff (rst)
    out_load && did |=> rsp.valid && rsp.flushed && !rsp.region_dirty)
    else $error("flushed item reports a dirty region");

endmodule

`default_nettype wire
